// ----- design/spr_pkg.sv -----
// Shared types and constants for the stepper pulse ramp controller.
package spr_pkg;

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QAW    = $clog2(QDEPTH);

	localparam logic [31:0] HOME_BACKOFF_STEPS = 32'd200;

	localparam logic [2:0] REG_RAMP_MODE       = 3'd0;
	localparam logic [2:0] REG_HALF_STEPS      = 3'd1;
	localparam logic [2:0] REG_DECEL_THRESHOLD = 3'd2;
	localparam logic [2:0] REG_MIN_PERIOD      = 3'd3;
	localparam logic [2:0] REG_RATE_Q15        = 3'd4;
	localparam logic [2:0] REG_INITIAL_PERIOD  = 3'd5;

	localparam logic [15:0] RST_MIN_PERIOD     = 16'd100;
	localparam logic [15:0] RST_RATE_Q15       = 16'd33423;
	localparam logic [15:0] RST_INITIAL_PERIOD = 16'd1000;

	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_PULSE = 2'd1,
		CMD_HOME  = 2'd2,
		CMD_STOP  = 2'd3
	} cmd_t;

	// One classified command as it waits between front and back.
	typedef struct packed {
		cmd_t        cmd;
		logic [31:0] step_count;
		logic        count_nz;
		logic        move_left;
		logic        switch_active;
	} cmd_entry_t;

endpackage

// ----- design/spr_front.sv -----
// Front end: accepts input items, decodes the command and queues them.
module spr_front
	import spr_pkg::*;
(
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // step_count[31:0], move_left[32], switch_active[33], zero
	input  logic [1:0]  s_tuser,   // cmd[1:0]
	output logic        push_valid,
	output cmd_entry_t  push_entry,
	input  logic        push_ready
);

	assign s_tready   = push_ready;
	assign push_valid = s_tvalid;

	always_comb begin
		push_entry.cmd           = cmd_t'(s_tuser);
		push_entry.step_count    = s_tdata[31:0];
		push_entry.count_nz      = |s_tdata[31:0];
		push_entry.move_left     = s_tdata[32];
		push_entry.switch_active = s_tdata[33];
	end

endmodule

// ----- design/spr_queue.sv -----
// Short command queue between the front end and the executor.
module spr_queue
	import spr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push_valid,
	input  cmd_entry_t push_entry,
	output logic       push_ready,
	output logic       pop_valid,
	output cmd_entry_t pop_entry,
	input  logic       pop_ready
);

	cmd_entry_t       mem_q [QDEPTH];
	logic [QAW-1:0]   wr_ptr_q;
	logic [QAW-1:0]   rd_ptr_q;
	logic [QAW:0]     count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != (QAW+1)'(QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_entry  = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (QAW+1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (QAW+1)'(1);
			end
		end
	end

endmodule

// ----- design/spr_exec.sv -----
// Back end: move state, period ramp, configuration registers and result register.
module spr_exec
	import spr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	input  logic        pop_valid,
	input  cmd_entry_t  pop_entry,
	output logic        pop_ready,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata
);

	// configuration
	logic        ramp_mode_q;
	logic [31:0] half_steps_q;
	logic [31:0] decel_threshold_q;
	logic [15:0] min_period_q;
	logic [15:0] rate_q15_q;

	// move state
	logic [31:0] remaining_q;
	logic [15:0] period_q;
	logic        moving_q;
	logic        direction_q;
	logic        home_flag_q;

	// result register
	logic        m_valid_q;
	logic [71:0] m_data_q;

	logic        pop;
	logic [16:0] fast_f;
	logic        use_fast;
	logic        scale_en;
	logic [16:0] factor;
	logic [32:0] prod;
	logic [17:0] scaled;
	logic [15:0] ramped;

	logic [31:0] remaining_d;
	logic [15:0] period_d;
	logic        moving_d;
	logic        direction_d;
	logic        home_flag_d;
	logic        started_d;
	logic        home_hit;
	logic        cfg_period_we;

	assign pop       = pop_valid && (!m_valid_q || m_tready);
	assign pop_ready = !m_valid_q || m_tready;
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = m_data_q;

	assign cfg_period_we = cfg_we && (cfg_index == REG_INITIAL_PERIOD);

	// ramp decision and scaled period
	always_comb begin
		fast_f = 17'h10000 - {1'b0, rate_q15_q};
		if (ramp_mode_q) begin
			use_fast = (remaining_q > half_steps_q);
			scale_en = 1'b1;
		end else if (remaining_q < decel_threshold_q) begin
			use_fast = 1'b0;
			scale_en = 1'b1;
		end else begin
			use_fast = 1'b1;
			scale_en = (period_q > min_period_q);
		end
		factor = use_fast ? fast_f : {1'b0, rate_q15_q};
		prod   = {17'b0, period_q} * {16'b0, factor};
		scaled = prod[32:15];
		ramped = (|scaled[17:16]) ? 16'hFFFF : scaled[15:0];
	end

	always_comb begin
		remaining_d = remaining_q;
		period_d    = period_q;
		moving_d    = moving_q;
		direction_d = direction_q;
		home_flag_d = home_flag_q;
		started_d   = 1'b0;
		home_hit    = pop_entry.switch_active && direction_q && !home_flag_q;
		unique case (pop_entry.cmd)
			CMD_START: begin
				if (pop_entry.count_nz) begin
					direction_d = pop_entry.move_left;
					// switch already active toward home: clear the count, leave the timer as it was
					if (pop_entry.switch_active && pop_entry.move_left && !home_flag_q) begin
						remaining_d = '0;
					end else begin
						remaining_d = pop_entry.step_count;
						moving_d    = 1'b1;
						started_d   = 1'b1;
					end
				end
			end
			CMD_PULSE: begin
				if (remaining_q != '0) begin
					if (remaining_q > 32'd1 && scale_en) begin
						period_d = ramped;
					end
					remaining_d = remaining_q - 32'd1;
				end else begin
					moving_d    = 1'b0;
					remaining_d = '0;
					home_flag_d = 1'b0;
				end
			end
			CMD_HOME: begin
				if (home_hit) begin
					home_flag_d = 1'b1;
					remaining_d = HOME_BACKOFF_STEPS;
					direction_d = 1'b1;
					moving_d    = 1'b1;
					started_d   = 1'b1;
				end
			end
			CMD_STOP: begin
				moving_d    = 1'b0;
				remaining_d = '0;
				home_flag_d = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_mode_q       <= 1'b0;
			half_steps_q      <= '0;
			decel_threshold_q <= '0;
			min_period_q      <= RST_MIN_PERIOD;
			rate_q15_q        <= RST_RATE_Q15;
			remaining_q       <= '0;
			period_q          <= RST_INITIAL_PERIOD;
			moving_q          <= 1'b0;
			direction_q       <= 1'b0;
			home_flag_q       <= 1'b0;
			m_valid_q         <= 1'b0;
		end else begin
			if (pop) begin
				remaining_q <= remaining_d;
				moving_q    <= moving_d;
				direction_q <= direction_d;
				home_flag_q <= home_flag_d;
				m_valid_q   <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			// a write of the initial period reloads the live period
			if (cfg_period_we) begin
				period_q <= cfg_wdata[15:0];
			end else if (pop) begin
				period_q <= period_d;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					REG_RAMP_MODE:       ramp_mode_q       <= cfg_wdata[0];
					REG_HALF_STEPS:      half_steps_q      <= cfg_wdata;
					REG_DECEL_THRESHOLD: decel_threshold_q <= cfg_wdata;
					REG_MIN_PERIOD:      min_period_q      <= cfg_wdata[15:0];
					REG_RATE_Q15:        rate_q15_q        <= cfg_wdata[15:0];
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			m_data_q <= {5'b0, started_d, home_flag_d, remaining_d, direction_d,
				moving_d, period_d[15:1], period_d};
		end
	end

endmodule

// ----- design/stepper_pulse_ramp_controller.sv -----
// Top level of the stepper pulse ramp controller.
//
//  channel  direction  handshake           payload
//  s_*      in         s_tvalid/s_tready   tuser cmd; tdata step_count, move_left, switch_active
//  m_*      out        m_tvalid/m_tready   tdata period, compare, running, dir, steps, home, start
//  cfg_*    in         cfg_we              cfg_index selects register, cfg_wdata value
//
// One item per cycle sustained while m_tready holds; each result is registered after its item leaves the queue.
// The executor closes its 16x17 ramp multiply, compares and state update combinationally.
// A four-entry queue lets the input keep flowing while a result waits on m_tready.
// Reset clears the queue, the move state and the result valid; period loads 1000.
module stepper_pulse_ramp_controller
	import spr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // step_count[31:0], move_left[32], switch_active[33], zero
	input  logic [1:0]  s_tuser,   // cmd[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata    // timer_period[15:0], timer_compare[30:16], running[31],
	                               // dir_left[32], steps_left[64:33], home_latched[65],
	                               // start_event[66], zero
);

	logic       push_valid;
	logic       push_ready;
	cmd_entry_t push_entry;
	logic       pop_valid;
	logic       pop_ready;
	cmd_entry_t pop_entry;

	spr_front u_front (
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.push_valid (push_valid),
		.push_entry (push_entry),
		.push_ready (push_ready)
	);

	spr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_entry (push_entry),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_entry  (pop_entry),
		.pop_ready  (pop_ready)
	);

	spr_exec u_exec (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.pop_valid (pop_valid),
		.pop_entry (pop_entry),
		.pop_ready (pop_ready),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

// ----- design/spr_checker.sv -----
// Port-level checks for the stepper pulse ramp controller, bound to the top level.
module spr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [71:0] m_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_compare_half: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[30:16] == m_tdata[15:1])
		else $error("compare is not half the period");

	a_start_running: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[66] |-> m_tdata[31])
		else $error("start event without running timer");

	a_idle_no_steps: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[31] |-> m_tdata[64:33] == 32'd0)
		else $error("steps left while timer stopped");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[71:67] == 5'd0)
		else $error("result padding not zero");

endmodule

bind stepper_pulse_ramp_controller spr_checker u_spr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ----- tb/spr_ramp_checker.sv -----
`timescale 1ns / 1ps
// Status predictor and stream checker for the stepper pulse ramp controller.
module spr_ramp_checker
	import spr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,   // step_count[31:0], move_left[32], switch_active[33], zero
	input  logic [1:0]  s_tuser,   // cmd[1:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [71:0] m_tdata,   // timer_period[15:0], timer_compare[30:16], running[31],
	                               // dir_left[32], steps_left[64:33], home_latched[65],
	                               // start_event[66], zero
	output int          errors,
	output int          pending
);

	typedef struct packed {
		logic [15:0] period;
		logic [14:0] compare;
		logic        running;
		logic        dir_left;
		logic [31:0] steps;
		logic        home;
		logic        started;
	} motor_status_t;

	// register copy
	logic        sym_mode;
	logic [31:0] half_pt;
	logic [31:0] decel_at;
	logic [15:0] period_floor;
	logic [15:0] rate;

	// move state
	logic [31:0] steps_q;
	logic [15:0] period_q;
	logic        motor_on;
	logic        dir_q;
	logic        homed;

	motor_status_t status_q[$];
	int            n_err;

	function automatic logic [15:0] scale_period(logic [15:0] p, logic [16:0] f);
		logic [32:0] prod;
		prod = ({17'd0, p} * {16'd0, f}) >> 15;
		return (prod > 33'd65535) ? 16'hFFFF : prod[15:0];
	endfunction

	function automatic void set_register(logic [2:0] idx, logic [31:0] val);
		case (idx)
			REG_RAMP_MODE:       sym_mode = val[0];
			REG_HALF_STEPS:      half_pt = val;
			REG_DECEL_THRESHOLD: decel_at = val;
			REG_MIN_PERIOD:      period_floor = val[15:0];
			REG_RATE_Q15:        rate = val[15:0];
			REG_INITIAL_PERIOD:  period_q = val[15:0];
			default: ;
		endcase
	endfunction

	function automatic void stop_motor();
		motor_on = 1'b0;
		steps_q = '0;
		homed = 1'b0;
	endfunction

	function automatic motor_status_t apply_command(cmd_t c, logic [31:0] cnt, logic l,
	                                                logic sw);
		logic [16:0]   fast;
		logic          started;
		motor_status_t r;
		started = 1'b0;
		fast = 17'h10000 - {1'b0, rate};
		case (c)
			CMD_START: begin
				if (cnt != 0) begin
					dir_q = l;
					// blocked start: clear the count but leave the timer as it was
					if (sw && dir_q && !homed) begin
						steps_q = '0;
					end else begin
						steps_q = cnt;
						motor_on = 1'b1;
						started = 1'b1;
					end
				end
			end
			CMD_PULSE: begin
				if (steps_q != 0) begin
					if (steps_q > 1) begin
						if (sym_mode)
							period_q = scale_period(period_q,
								(steps_q > half_pt) ? fast : {1'b0, rate});
						else if (steps_q < decel_at)
							period_q = scale_period(period_q, {1'b0, rate});
						else if (period_q > period_floor)
							period_q = scale_period(period_q, fast);
					end
					steps_q = steps_q - 32'd1;
				end else begin
					stop_motor();
				end
			end
			CMD_HOME: begin
				if (sw && dir_q && !homed) begin
					homed = 1'b1;
					steps_q = HOME_BACKOFF_STEPS;
					dir_q = 1'b1;
					motor_on = 1'b1;
					started = 1'b1;
				end
			end
			default: stop_motor();
		endcase
		r.period   = period_q;
		r.compare  = period_q[15:1];
		r.running  = motor_on;
		r.dir_left = dir_q;
		r.steps    = steps_q;
		r.home     = homed;
		r.started  = started;
		return r;
	endfunction

	function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			n_err++;
			if (n_err <= 10)
				$display("%0t: status mismatch on %s: expected %0h, got %0h",
					$time, what, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		motor_status_t want;
		motor_status_t got;
		if (!arst_n) begin
			sym_mode     = 1'b0;
			half_pt      = '0;
			decel_at     = '0;
			period_floor = RST_MIN_PERIOD;
			rate         = RST_RATE_Q15;
			steps_q      = '0;
			period_q     = RST_INITIAL_PERIOD;
			motor_on     = 1'b0;
			dir_q        = 1'b0;
			homed        = 1'b0;
			status_q.delete();
			n_err        = 0;
		end else begin
			if (cfg_we)
				set_register(cfg_index, cfg_wdata);
			// compare before queuing this edge's item so a result cannot match its own input
			if (m_tvalid && m_tready) begin
				if (status_q.size() == 0) begin
					n_err++;
					if (n_err <= 10)
						$display("%0t: status item with nothing outstanding: %h",
							$time, m_tdata);
				end else begin
					want = status_q.pop_front();
					got.period   = m_tdata[15:0];
					got.compare  = m_tdata[30:16];
					got.running  = m_tdata[31];
					got.dir_left = m_tdata[32];
					got.steps    = m_tdata[64:33];
					got.home     = m_tdata[65];
					got.started  = m_tdata[66];
					check_field("timer_period", 32'(want.period), 32'(got.period));
					check_field("timer_compare", 32'(want.compare), 32'(got.compare));
					check_field("running", 32'(want.running), 32'(got.running));
					check_field("dir_left", 32'(want.dir_left), 32'(got.dir_left));
					check_field("steps_left", want.steps, got.steps);
					check_field("home_latched", 32'(want.home), 32'(got.home));
					check_field("start_event", 32'(want.started), 32'(got.started));
				end
			end
			if (s_tvalid && s_tready)
				status_q.push_back(apply_command(cmd_t'(s_tuser), s_tdata[31:0],
					s_tdata[32], s_tdata[33]));
		end
		pending <= status_q.size();
		errors  <= n_err;
	end

endmodule

// ----- tb/stepper_pulse_ramp_controller_tb.sv -----
`timescale 1ns / 1ps
// Stimulus, idling and verdict for the stepper pulse ramp controller testbench.
module stepper_pulse_ramp_controller_tb;
	import spr_pkg::*;

	localparam int RAND_ITEMS   = 1550;
	localparam int NUM_SETTINGS = 7;
	localparam int STALL_LIMIT  = 2000;
	localparam int TAIL_CYCLES  = 8;

	// indexes past the register list; writes there must be ignored
	localparam logic [2:0] REG_SPARE_LO = 3'd6;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;   // step_count[31:0], move_left[32], switch_active[33], zero
	logic [1:0]  s_tuser;   // cmd[1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;   // timer_period[15:0], timer_compare[30:16], running[31],
	                        // dir_left[32], steps_left[64:33], home_latched[65],
	                        // start_event[66], zero
	int          errors;
	int          pending;

	int src_idle_pct;
	int snk_idle_pct;
	int sent;
	int stall_cycles;

	stepper_pulse_ramp_controller u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	spr_ramp_checker u_ramp_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.errors    (errors),
		.pending   (pending)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic send_item(cmd_t c, logic [31:0] cnt, logic l, logic sw);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= c;
		s_tdata  <= {6'd0, sw, l, cnt};
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
	endtask

	task automatic program_setting(int setting);
		logic        mode;
		logic [31:0] half;
		logic [31:0] dec;
		logic [15:0] floor_p;
		logic [15:0] r;
		logic [15:0] init;
		case (setting)
			0: begin
				mode = 1'b1; half = 32'd20; dec = 32'd0;
				floor_p = 16'd100; r = 16'd33423; init = 16'd1000;
			end
			1: begin
				mode = 1'b0; half = 32'd0; dec = 32'd10;
				floor_p = 16'd50; r = 16'd36000; init = 16'd2000;
			end
			2: begin
				mode = 1'b1; half = 32'hFFFF_FFFF; dec = 32'hFFFF_FFFF;
				floor_p = 16'hFFFF; r = 16'hFFFF; init = 16'hFFFF;
			end
			3: begin
				mode = 1'b0; half = 32'd0; dec = 32'd0;
				floor_p = 16'd1; r = 16'd32768; init = 16'd1;
			end
			4: begin
				// rate below one: speed-up doubles, slow-down drives the period to zero
				mode = 1'b1; half = 32'd8; dec = 32'd5;
				floor_p = 16'd0; r = 16'd0; init = 16'd3;
			end
			5: begin
				mode = 1'b0; half = $urandom; dec = 32'd0;
				floor_p = 16'd0; r = 16'd40000; init = 16'd0;
			end
			default: begin
				mode = 1'($urandom_range(0, 1));
				half = $urandom_range(0, 40);
				dec = $urandom_range(0, 40);
				floor_p = 16'($urandom_range(1, 3000));
				r = 16'($urandom_range(32768, 65535));
				init = 16'($urandom_range(1, 65535));
			end
		endcase
		// upper bits of the narrow registers carry noise
		write_reg(REG_RAMP_MODE, {31'($urandom), mode});
		write_reg(REG_HALF_STEPS, half);
		write_reg(REG_DECEL_THRESHOLD, dec);
		write_reg(REG_MIN_PERIOD, {16'($urandom), floor_p});
		write_reg(REG_RATE_Q15, {16'($urandom), r});
		write_reg(REG_INITIAL_PERIOD, {16'($urandom), init});
		if (setting == 0) begin
			write_reg(REG_SPARE_LO, $urandom);
			write_reg(REG_SPARE_HI, $urandom);
		end
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_sequence();
		int          kind;
		int          n;
		logic [31:0] cnt;
		kind = $urandom_range(0, 99);
		if (kind < 65) begin
			// ordinary move: start, pulse to the end, sometimes past it or cut short
			cnt = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 48);
			send_item(CMD_START, cnt, 1'($urandom), ($urandom_range(0, 9) == 0));
			n = (cnt > 60) ? $urandom_range(1, 60) : cnt + $urandom_range(0, 2);
			for (int k = 0; k < n; k++) begin
				if ($urandom_range(0, 39) == 0) begin
					send_item(CMD_STOP, $urandom, 1'($urandom), 1'($urandom));
					break;
				end
				send_item(CMD_PULSE, $urandom, 1'($urandom), 1'($urandom));
			end
		end else if (kind < 85) begin
			// homing: move left, hit the switch, back off
			n = $urandom_range(0, 6);
			send_item(CMD_START, $urandom_range(n + 1, 60), 1'b1, 1'b0);
			repeat (n) send_item(CMD_PULSE, $urandom, 1'($urandom), 1'($urandom));
			send_item(CMD_HOME, $urandom, 1'($urandom), ($urandom_range(0, 4) != 0));
			n = ($urandom_range(0, 7) == 0) ? 202 : $urandom_range(0, 30);
			repeat (n) send_item(CMD_PULSE, $urandom, 1'($urandom), 1'($urandom));
			if ($urandom_range(0, 1) == 1)
				send_item(CMD_STOP, $urandom, 1'($urandom), 1'($urandom));
		end else begin
			repeat ($urandom_range(1, 6))
				send_item(cmd_t'($urandom_range(0, 3)),
					($urandom_range(0, 1) == 1) ? $urandom : $urandom_range(0, 3),
					1'($urandom), 1'($urandom));
		end
	endtask

	initial begin
		int rand_base;
		clk          = 1'b0;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_wdata    = '0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = CMD_STOP;
		m_tready     = 1'b0;
		src_idle_pct = 16;
		snk_idle_pct = 47;
		sent         = 0;
		stall_cycles = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed part under the reset settings
		send_item(CMD_PULSE, 32'd0, 1'b0, 1'b0);             // pulse with nothing to do
		send_item(CMD_START, 32'd0, 1'b1, 1'b0);             // zero count is ignored
		send_item(CMD_START, 32'hFFFF_FFFF, 1'b0, 1'b1);     // longest move, right
		repeat (3) send_item(CMD_PULSE, 32'hFFFF_FFFF, 1'b1, 1'b1);
		send_item(CMD_START, 32'd1, 1'b1, 1'b0);             // restart keeps the period
		send_item(CMD_PULSE, 32'd0, 1'b0, 1'b0);             // last step, no ramp
		send_item(CMD_PULSE, 32'd0, 1'b0, 1'b0);             // nothing left: halts
		send_item(CMD_START, 32'd3, 1'b0, 1'b0);
		send_item(CMD_START, 32'd7, 1'b1, 1'b1);             // blocked by the switch
		send_item(CMD_HOME, 32'd0, 1'b0, 1'b1);              // latch home, back off
		send_item(CMD_HOME, 32'd0, 1'b1, 1'b1);              // already latched
		send_item(CMD_START, 32'd9, 1'b1, 1'b1);             // latched: start goes through
		repeat (2) send_item(CMD_PULSE, 32'hFFFF_FFFF, 1'b1, 1'b0);
		send_item(CMD_STOP, 32'hFFFF_FFFF, 1'b1, 1'b1);
		send_item(CMD_START, 32'd4, 1'b1, 1'b0);
		send_item(CMD_HOME, 32'd0, 1'b0, 1'b0);              // switch not active
		send_item(CMD_START, 32'd4, 1'b0, 1'b0);
		send_item(CMD_HOME, 32'd0, 1'b1, 1'b1);              // moving right
		send_item(CMD_STOP, 32'd0, 1'b0, 1'b0);
		drain();

		rand_base = sent;
		for (int seg = 0; seg < NUM_SETTINGS; seg++) begin
			program_setting(seg);
			while (sent < rand_base + (seg + 1) * RAND_ITEMS / NUM_SETTINGS) begin
				if (sent < rand_base + RAND_ITEMS / 3) begin
					src_idle_pct = 16;
					snk_idle_pct = 47;
				end else if (sent < rand_base + 2 * RAND_ITEMS / 3) begin
					src_idle_pct = 47;
					snk_idle_pct = 16;
				end else begin
					src_idle_pct = 0;
					snk_idle_pct = 0;
				end
				random_sequence();
			end
			drain();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
